### sv/qrpm_pkg.sv
package qrpm_pkg;

  // Field and register widths.
  localparam int IDX_W       = 15;
  localparam int SIDE_W      = 8;
  localparam int VER_W       = 6;
  localparam int MASK_W      = 4;
  localparam int COORD_W     = 8;
  localparam int MAX_ALIGN_COORDS = 7;
  localparam int ALIGN_W     = COORD_W * MAX_ALIGN_COORDS;
  localparam int ALIGN_CNT_W = 3;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = ALIGN_W;

  // Version limits and the side length formula.
  localparam logic [VER_W-1:0] VER_MIN = 6'd1;
  localparam logic [VER_W-1:0] VER_MAX = 6'd40;
  localparam logic [VER_W-1:0] VER_INFO_MIN = 6'd7;

  // Divider geometry: half the bit index divided by the side length.
  // The quotient never exceeds 16383 / 21, so ten bits hold it.
  localparam int DIVIDEND_W = IDX_W - 1;
  localparam int QUOT_W     = 10;
  localparam int REM_W      = QUOT_W - 1 + SIDE_W;
  localparam int DIV_STEPS  = 2;
  localparam int DIV_STAGES = (QUOT_W + DIV_STEPS - 1) / DIV_STEPS;

  // Input register, divider stages, coordinate, area-hit and output stages.
  localparam int PIPE_DEPTH = DIV_STAGES + 4;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_VERSION     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MASK        = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ALIGN_COORD = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_ALIGN_COUNT = 2'd3;

  // Mask pattern codes.
  localparam logic [MASK_W-1:0] MASK_PAT0 = 4'd0;
  localparam logic [MASK_W-1:0] MASK_PAT1 = 4'd1;
  localparam logic [MASK_W-1:0] MASK_PAT2 = 4'd2;
  localparam logic [MASK_W-1:0] MASK_PAT3 = 4'd3;
  localparam logic [MASK_W-1:0] MASK_PAT4 = 4'd4;
  localparam logic [MASK_W-1:0] MASK_PAT5 = 4'd5;
  localparam logic [MASK_W-1:0] MASK_PAT6 = 4'd6;
  localparam logic [MASK_W-1:0] MASK_PAT7 = 4'd7;
  localparam logic [MASK_W-1:0] MASK_NONE = 4'd8;
  localparam logic [MASK_W-1:0] MASK_ALL  = 4'd9;

  typedef enum logic [1:0] {
    ST_PLACED  = 2'd0,
    ST_SKIPPED = 2'd1,
    ST_END     = 2'd2
  } place_status_t;

  // Side information that rides along with a request through the divider.
  typedef struct packed {
    logic odd;
    logic late_col;
  } qrpm_tag_t;

  // Symbol side length for a version, with the version clamped to 1..40.
  function automatic logic [SIDE_W-1:0] qrpm_side(input logic [VER_W-1:0] ver);
    logic [VER_W-1:0] v;
    v = ver;
    if (v < VER_MIN) v = VER_MIN;
    if (v > VER_MAX) v = VER_MAX;
    return SIDE_W'(17) + {v, 2'b00};
  endfunction

endpackage

### sv/qrpm_div.sv
module qrpm_div (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  input  logic [qrpm_pkg::DIVIDEND_W-1:0]     in_dividend,
  input  logic [qrpm_pkg::SIDE_W-1:0]         in_divisor,
  input  qrpm_pkg::qrpm_tag_t                 in_tag,
  output logic                                out_valid,
  output logic [qrpm_pkg::QUOT_W-1:0]         out_quot,
  output logic [qrpm_pkg::SIDE_W-1:0]         out_rem,
  output qrpm_pkg::qrpm_tag_t                 out_tag
);

  localparam int NS = qrpm_pkg::DIV_STAGES;

  logic                              stage_valid [0:NS];
  logic [qrpm_pkg::REM_W-1:0]        stage_rem   [0:NS];
  logic [qrpm_pkg::QUOT_W-1:0]       stage_quot  [0:NS];
  logic [qrpm_pkg::SIDE_W-1:0]       stage_dsr   [0:NS];
  qrpm_pkg::qrpm_tag_t               stage_tag   [0:NS];

  assign stage_valid[0] = in_valid;
  assign stage_rem[0]   = qrpm_pkg::REM_W'(in_dividend);
  assign stage_quot[0]  = '0;
  assign stage_dsr[0]   = in_divisor;
  assign stage_tag[0]   = in_tag;

  // Restoring division, most significant quotient bit first; each stage
  // tries DIV_STEPS shifted copies of the divisor.
  for (genvar g = 0; g < NS; g++) begin : g_stage
    logic [qrpm_pkg::REM_W-1:0]  rem_c;
    logic [qrpm_pkg::QUOT_W-1:0] quot_c;

    always_comb begin
      logic [qrpm_pkg::REM_W-1:0] trial;
      int j;
      rem_c  = stage_rem[g];
      quot_c = stage_quot[g];
      for (int t = 0; t < qrpm_pkg::DIV_STEPS; t++) begin
        j = qrpm_pkg::QUOT_W - 1 - g * qrpm_pkg::DIV_STEPS - t;
        if (j >= 0) begin
          trial = qrpm_pkg::REM_W'(stage_dsr[g]) << j;
          if (rem_c >= trial) begin
            rem_c  = rem_c - trial;
            quot_c = {quot_c[qrpm_pkg::QUOT_W-2:0], 1'b1};
          end else begin
            quot_c = {quot_c[qrpm_pkg::QUOT_W-2:0], 1'b0};
          end
        end
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        stage_valid[g+1] <= 1'b0;
      end else begin
        stage_valid[g+1] <= stage_valid[g];
      end
      stage_rem[g+1]  <= rem_c;
      stage_quot[g+1] <= quot_c;
      stage_dsr[g+1]  <= stage_dsr[g];
      stage_tag[g+1]  <= stage_tag[g];
    end
  end

  assign out_valid = stage_valid[NS];
  assign out_quot  = stage_quot[NS];
  assign out_rem   = stage_rem[NS][qrpm_pkg::SIDE_W-1:0];
  assign out_tag   = stage_tag[NS];

endmodule

### sv/qr_module_placement_mapper.sv
// An accepted request passes the input register, divider, coordinate, hit and
// output stages to its result with done high; nothing can stall the pipeline.
// Throughput: one request per cycle, every cycle; busy never rises. Five of the
// nine stages are the pipelined divider of the bit index by the side length.
// Reset (rst, synchronous, active high) empties the pipeline and loads
// version 1, no mask and an empty alignment list.
module qr_module_placement_mapper (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  output logic                                busy,
  input  logic [qrpm_pkg::IDX_W-1:0]          bit_index,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [qrpm_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [qrpm_pkg::CFG_DATA_W-1:0]     cfg_data,
  output logic                                done,
  output logic [1:0]                          place_status,
  output logic [qrpm_pkg::SIDE_W-1:0]         module_col,
  output logic [qrpm_pkg::SIDE_W-1:0]         module_row,
  output logic                                mask_bit
);

  localparam int NA = qrpm_pkg::MAX_ALIGN_COORDS;

  // Configuration registers. Writes must come only with no request in flight;
  // the block does not enforce it. Every stage below reads them directly.
  logic [qrpm_pkg::VER_W-1:0]       symbol_version;
  logic [qrpm_pkg::MASK_W-1:0]      mask_pattern;
  logic [qrpm_pkg::ALIGN_W-1:0]     alignment_coords;
  logic [qrpm_pkg::ALIGN_CNT_W-1:0] alignment_count;

  assign cfg_ready = 1'b1;
  assign busy      = 1'b0;

  always_ff @(posedge clk) begin
    if (rst) begin
      symbol_version   <= qrpm_pkg::VER_MIN;
      mask_pattern     <= qrpm_pkg::MASK_NONE;
      alignment_coords <= '0;
      alignment_count  <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        qrpm_pkg::CFG_VERSION:     symbol_version   <= cfg_data[qrpm_pkg::VER_W-1:0];
        qrpm_pkg::CFG_MASK:        mask_pattern     <= cfg_data[qrpm_pkg::MASK_W-1:0];
        qrpm_pkg::CFG_ALIGN_COORD: alignment_coords <= cfg_data[qrpm_pkg::ALIGN_W-1:0];
        qrpm_pkg::CFG_ALIGN_COUNT: alignment_count  <= cfg_data[qrpm_pkg::ALIGN_CNT_W-1:0];
        default: ;
      endcase
    end
  end

  // The side length is a pure function of the version register.
  logic [qrpm_pkg::SIDE_W-1:0] side;
  assign side = qrpm_pkg::qrpm_side(symbol_version);

  // ---------------------------------------------------------------------
  // Input stage. The index is registered, then the late-column flag is
  // worked out: past (side-7)*side the path has stepped over the vertical
  // timing column, so every later column moves one further left.
  // ---------------------------------------------------------------------
  logic                          in_vld;
  logic [qrpm_pkg::IDX_W-1:0]    in_idx;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_vld <= 1'b0;
    end else begin
      in_vld <= start && !busy;
    end
    in_idx <= bit_index;
  end

  logic [15:0]                   late_thr;
  qrpm_pkg::qrpm_tag_t           in_tag;

  always_comb begin
    late_thr        = {8'd0, side - 8'd7} * {8'd0, side};
    in_tag.odd      = in_idx[0];
    in_tag.late_col = {1'b0, in_idx} >= late_thr;
  end

  // Half the index divided by the side: the quotient counts vertical half
  // sweeps, the remainder is the place within the current sweep.
  logic                          dv_vld;
  logic [qrpm_pkg::QUOT_W-1:0]   dv_quot;
  logic [qrpm_pkg::SIDE_W-1:0]   dv_rem;
  qrpm_pkg::qrpm_tag_t           dv_tag;

  qrpm_div u_div (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_vld),
    .in_dividend (in_idx[qrpm_pkg::IDX_W-1:1]),
    .in_divisor  (side),
    .in_tag      (in_tag),
    .out_valid   (dv_vld),
    .out_quot    (dv_quot),
    .out_rem     (dv_rem),
    .out_tag     (dv_tag)
  );

  // ---------------------------------------------------------------------
  // Coordinate stage. The quotient counts column pairs from the right
  // edge. Its bit 0 picks the sweep direction: even pairs run upward from
  // the bottom row, odd pairs run downward from the top row.
  // ---------------------------------------------------------------------
  logic [8:0]                    k_c;
  logic [11:0]                   x_c;
  logic [9:0]                    y_c;

  always_comb begin
    k_c = {1'b0, dv_rem} + (dv_quot[0] ? {1'b0, side} : 9'd0);
    x_c = {4'd0, side} - 12'd1 - {11'd0, dv_tag.odd}
        - {1'b0, dv_quot, 1'b0} - {11'd0, dv_tag.late_col};
    if (dv_quot[0]) begin
      y_c = {1'b0, k_c} - {2'd0, side};
    end else begin
      y_c = {2'd0, side} - 10'd1 - {1'b0, k_c};
    end
  end

  logic                          c_vld;
  logic                          c_end;
  logic [qrpm_pkg::SIDE_W-1:0]   c_x;
  logic [qrpm_pkg::SIDE_W-1:0]   c_y;

  always_ff @(posedge clk) begin
    if (rst) begin
      c_vld <= 1'b0;
    end else begin
      c_vld <= dv_vld;
    end
    c_end <= x_c[11] || y_c[9];
    c_x   <= x_c[qrpm_pkg::SIDE_W-1:0];
    c_y   <= y_c[qrpm_pkg::SIDE_W-1:0];
  end

  // ---------------------------------------------------------------------
  // Hit stage. Each alignment coordinate is compared against both axes,
  // and the thirds needed by the mask patterns are found by a multiply
  // with 171/512, which is exact for values below 256.
  // ---------------------------------------------------------------------
  logic [NA-1:0]                 hx_c;
  logic [NA-1:0]                 hy_c;
  logic [15:0]                   xp_c;
  logic [15:0]                   yp_c;
  logic [6:0]                    xq_c;
  logic [6:0]                    yq_c;
  logic [7:0]                    xr_c;
  logic [7:0]                    yr_c;

  always_comb begin
    logic [8:0] cc;
    for (int a = 0; a < NA; a++) begin
      cc      = {1'b0, alignment_coords[qrpm_pkg::COORD_W*a +: qrpm_pkg::COORD_W]};
      hx_c[a] = ({1'b0, c_x} + 9'd2 >= cc) && ({1'b0, c_x} <= cc + 9'd2);
      hy_c[a] = ({1'b0, c_y} + 9'd2 >= cc) && ({1'b0, c_y} <= cc + 9'd2);
    end
    xp_c = {8'd0, c_x} * 16'd171;
    yp_c = {8'd0, c_y} * 16'd171;
    xq_c = xp_c[15:9];
    yq_c = yp_c[15:9];
    xr_c = c_x - ({1'b0, xq_c} + {xq_c, 1'b0});
    yr_c = c_y - ({1'b0, yq_c} + {yq_c, 1'b0});
  end

  logic                          h_vld;
  logic                          h_end;
  logic [qrpm_pkg::SIDE_W-1:0]   h_x;
  logic [qrpm_pkg::SIDE_W-1:0]   h_y;
  logic [NA-1:0]                 h_hx;
  logic [NA-1:0]                 h_hy;
  logic [1:0]                    h_xm3;
  logic [1:0]                    h_ym3;
  logic                          h_xd3;

  always_ff @(posedge clk) begin
    if (rst) begin
      h_vld <= 1'b0;
    end else begin
      h_vld <= c_vld;
    end
    h_end <= c_end;
    h_x   <= c_x;
    h_y   <= c_y;
    h_hx  <= hx_c;
    h_hy  <= hy_c;
    h_xm3 <= xr_c[1:0];
    h_ym3 <= yr_c[1:0];
    h_xd3 <= xq_c[0];
  end

  // ---------------------------------------------------------------------
  // Classification and mask stage, registered straight onto the ports.
  // Alignment centres are all coordinate pairs except the three finder
  // corners: first/first, first/last and last/first.
  // ---------------------------------------------------------------------
  logic                          align_hit;
  logic                          func_hit;
  logic                          mask_c;

  always_comb begin
    logic [qrpm_pkg::ALIGN_CNT_W-1:0] last;
    logic [qrpm_pkg::ALIGN_CNT_W-1:0] ai;
    logic [qrpm_pkg::ALIGN_CNT_W-1:0] bi;
    logic                             corner;
    logic [qrpm_pkg::SIDE_W-1:0]      s8;
    logic [qrpm_pkg::SIDE_W-1:0]      s9;
    logic [qrpm_pkg::SIDE_W-1:0]      s11;
    logic                             finder;
    logic                             format;
    logic                             timing;
    logic                             ver_info;
    logic [2:0]                       sum3;
    logic [3:0]                       prod;
    logic [1:0]                       pm3;
    logic                             par;
    logic                             p2;

    last      = alignment_count - 3'd1;
    align_hit = 1'b0;
    for (int a = 0; a < NA; a++) begin
      for (int b = 0; b < NA; b++) begin
        ai     = qrpm_pkg::ALIGN_CNT_W'(a);
        bi     = qrpm_pkg::ALIGN_CNT_W'(b);
        corner = (ai == '0 && bi == '0) || (ai == '0 && bi == last)
              || (ai == last && bi == '0);
        if (ai < alignment_count && bi < alignment_count && !corner
            && h_hx[a] && h_hy[b]) begin
          align_hit = 1'b1;
        end
      end
    end

    s8  = side - 8'd8;
    s9  = side - 8'd9;
    s11 = side - 8'd11;

    finder = (h_x < 8'd8 && h_y < 8'd8) || (h_x < 8'd8 && h_y >= s8)
          || (h_x >= s8 && h_y < 8'd8);
    format = (h_y == 8'd8 && (h_x <= 8'd8 || h_x >= s8))
          || (h_x == 8'd8 && (h_y <= 8'd8 || h_y >= s8));
    timing = (h_x == 8'd6) || (h_y == 8'd6);
    ver_info = (symbol_version >= qrpm_pkg::VER_INFO_MIN)
            && ((h_x < 8'd7 && h_y >= s11 && h_y <= s9)
             || (h_y < 8'd7 && h_x >= s11 && h_x <= s9));
    func_hit = finder || format || timing || ver_info || align_hit;

    // Residues mod 3 of the sum and of the product come from the residues
    // of the coordinates.
    sum3 = {1'b0, h_xm3} + {1'b0, h_ym3};
    if (sum3 >= 3'd3) sum3 = sum3 - 3'd3;
    prod = {2'd0, h_xm3} * {2'd0, h_ym3};
    pm3  = (prod == 4'd4) ? 2'd1 : prod[1:0];
    par  = h_x[0] ^ h_y[0];
    p2   = h_x[0] & h_y[0];

    case (mask_pattern)
      qrpm_pkg::MASK_PAT0: mask_c = !par;
      qrpm_pkg::MASK_PAT1: mask_c = !h_y[0];
      qrpm_pkg::MASK_PAT2: mask_c = (h_xm3 == 2'd0);
      qrpm_pkg::MASK_PAT3: mask_c = (sum3 == 3'd0);
      qrpm_pkg::MASK_PAT4: mask_c = !(h_y[1] ^ h_xd3);
      qrpm_pkg::MASK_PAT5: mask_c = !p2 && (pm3 == 2'd0);
      qrpm_pkg::MASK_PAT6: mask_c = !(p2 ^ pm3[0]);
      qrpm_pkg::MASK_PAT7: mask_c = !(pm3[0] ^ par);
      qrpm_pkg::MASK_ALL:  mask_c = 1'b1;
      default:             mask_c = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= h_vld;
    end
    if (h_end) begin
      place_status <= qrpm_pkg::ST_END;
      module_col   <= '0;
      module_row   <= '0;
      mask_bit     <= 1'b0;
    end else if (func_hit) begin
      place_status <= qrpm_pkg::ST_SKIPPED;
      module_col   <= '0;
      module_row   <= '0;
      mask_bit     <= 1'b0;
    end else begin
      place_status <= qrpm_pkg::ST_PLACED;
      module_col   <= h_x;
      module_row   <= h_y;
      mask_bit     <= mask_c;
    end
  end

endmodule

### sv/qrpm_port_checker.sv
module qrpm_port_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          start,
  input logic                          busy,
  input logic                          done,
  input logic [1:0]                    place_status,
  input logic [qrpm_pkg::SIDE_W-1:0]   module_col,
  input logic [qrpm_pkg::SIDE_W-1:0]   module_row,
  input logic                          mask_bit
);

  // Every accepted request yields exactly one result at a fixed distance.
  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    start && !busy |-> ##(qrpm_pkg::PIPE_DEPTH) done)
    else $error("accepted request produced no result");

  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, qrpm_pkg::PIPE_DEPTH))
    else $error("result without a matching request");

  // Skipped and past-end results carry zero coordinates and mask.
  a_zero_unplaced: assert property (@(posedge clk) disable iff (rst)
    done && place_status != qrpm_pkg::ST_PLACED
      |-> module_col == '0 && module_row == '0 && !mask_bit)
    else $error("unplaced result carries coordinates");

  // The timing lines are never data modules.
  a_no_timing: assert property (@(posedge clk) disable iff (rst)
    done && place_status == qrpm_pkg::ST_PLACED
      |-> module_col != 8'd6 && module_row != 8'd6)
    else $error("data placed on a timing line");

endmodule

bind qr_module_placement_mapper qrpm_port_checker u_port_checker (.*);
